>>> sv/crcfd_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the frame decoder.
package crcfd_pkg;

    // Frame layout
    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned CRC_BYTES = 4;
    localparam int unsigned MIN_FRAME = HDR_BYTES + CRC_BYTES;

    // Byte counter width and field widths
    localparam int unsigned CNT_W   = 34;
    localparam int unsigned END_W   = CNT_W + 1;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [15:0] MAGIC_RST   = 16'h4D43;
    localparam logic [7:0]  VERSION_RST = 8'h01;

    // Result queue depth, a power of two of at least two
    localparam int unsigned RES_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1
    } t_cfg_idx;

    // Frame status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_BAD_LENGTH  = 3'd4,
        ST_CRC_ERR     = 3'd5
    } t_status;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] msg_type;
        logic [31:0] payload_length;
        t_status     status;
        logic        last;
    } t_result;

    // Fold one byte into the CRC register, one bit a step
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

>>> sv/crc32_frame_decoder.sv
// Top level: streaming decoder for length-prefixed frames closed by a CRC-32.
//
//  channel  | direction | handshake            | fields
//  ---------+-----------+----------------------+----------------------------------------
//  input    | in        | i_valid / o_stall    | i_rx_byte, i_frame_end
//  result   | out       | o_valid / i_stall    | o_kind, o_payload_byte, o_msg_type,
//           |           |                      | o_payload_length, o_status, o_last
//  config   | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One byte is accepted per cycle while o_stall is low; the CRC step, field capture
// and status decision sit between the frame state registers and a small result queue.
// A frame-end byte that is also a payload byte yields two results; the queue drains
// one a cycle while i_stall is low, so the input stalls only when fewer than two entries
// are free. Results pass through the queue's registers before they can leave.
// Reset is synchronous and clears the frame state, queue and registers at once.
module crc32_frame_decoder
    import crcfd_pkg::*;
#(
    parameter int unsigned DEPTH = RES_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_frame_end,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_kind,
    output logic [7:0]           o_payload_byte,
    output logic [15:0]          o_msg_type,
    output logic [31:0]          o_payload_length,
    output logic [2:0]           o_status,
    output logic                 o_last,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned QCNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration registers
    logic [15:0] r_exp_magic;
    logic [7:0]  r_exp_version;

    // Frame state
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [31:0]      r_crc,        n_crc;
    logic [15:0]      r_type,       n_type;
    logic [31:0]      r_length,     n_length;
    logic [31:0]      r_rx_crc,     n_rx_crc;
    logic             r_magic_ok,   n_magic_ok;
    logic             r_version_ok, n_version_ok;
    logic [END_W-1:0] r_body_end,   n_body_end;
    logic [END_W-1:0] r_crc_end,    n_crc_end;

    logic             accept;
    logic             is_hdr, is_pay, is_crc;
    logic [END_W-1:0] pos;
    logic [END_W-1:0] size;
    logic [31:0]      crc_upd;
    t_status          status;
    t_result          res_pay, res_st, res_d0;
    logic [1:0]       push_cnt;
    t_result          head;
    logic [QCNT_W-1:0] q_count;
    logic             pop;

    assign accept = i_valid && !o_stall;
    assign pos    = {1'b0, r_byte_count};

    // Classify the byte position
    assign is_hdr  = r_byte_count < CNT_W'(HDR_BYTES);
    assign is_pay  = !is_hdr && (pos < r_body_end);
    assign is_crc  = !is_hdr && !is_pay && (pos < r_crc_end);
    assign crc_upd = crc_byte(r_crc, i_rx_byte);

    // Next frame state for this byte
    always_comb begin
        n_magic_ok   = r_magic_ok;
        n_version_ok = r_version_ok;
        n_type       = r_type;
        n_length     = r_length;
        n_body_end   = r_body_end;
        n_crc_end    = r_crc_end;
        if (r_byte_count == CNT_W'(0)) begin
            n_magic_ok = (i_rx_byte == r_exp_magic[15:8]);
        end else if (r_byte_count == CNT_W'(1)) begin
            n_magic_ok = r_magic_ok && (i_rx_byte == r_exp_magic[7:0]);
        end else if (r_byte_count == CNT_W'(2)) begin
            n_version_ok = (i_rx_byte == r_exp_version);
        end else if (r_byte_count == CNT_W'(4) || r_byte_count == CNT_W'(5)) begin
            n_type = {r_type[7:0], i_rx_byte};
        end else if (r_byte_count >= CNT_W'(6) && is_hdr) begin
            n_length   = {r_length[23:0], i_rx_byte};
            n_body_end = {3'd0, n_length} + END_W'(HDR_BYTES);
            n_crc_end  = {3'd0, n_length} + END_W'(MIN_FRAME);
        end
        n_crc        = (is_hdr || is_pay) ? crc_upd : r_crc;
        n_rx_crc     = is_crc ? {r_rx_crc[23:0], i_rx_byte} : r_rx_crc;
        n_byte_count = (r_byte_count != CNT_MAX) ? r_byte_count + CNT_W'(1) : r_byte_count;
    end

    // Decide the frame status, first failing check wins
    assign size = {1'b0, n_byte_count};
    always_comb begin
        if (size < END_W'(MIN_FRAME)) begin
            status = ST_TOO_SHORT;
        end else if (!n_magic_ok) begin
            status = ST_BAD_MAGIC;
        end else if (!n_version_ok) begin
            status = ST_BAD_VERSION;
        end else if (size < n_crc_end) begin
            status = ST_BAD_LENGTH;
        end else if (n_rx_crc != ~n_crc) begin
            status = ST_CRC_ERR;
        end else begin
            status = ST_OK;
        end
    end

    // Build result items; a payload item goes ahead of the status item
    always_comb begin
        res_pay                = '0;
        res_pay.kind           = 1'b0;
        res_pay.payload_byte   = i_rx_byte;
        res_pay.status         = ST_OK;
        res_st                 = '0;
        res_st.kind            = 1'b1;
        res_st.msg_type        = n_type;
        res_st.payload_length  = n_length;
        res_st.status          = status;
        res_st.last            = 1'b1;
        res_d0                 = is_pay ? res_pay : res_st;
        push_cnt               = '0;
        if (accept) begin
            push_cnt = 2'(is_pay) + 2'(i_frame_end);
        end
    end

    // Hold configuration; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= MAGIC_RST;
            r_exp_version <= VERSION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC:   r_exp_magic   <= i_cfg_data[15:0];
                CFG_VERSION: r_exp_version <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Advance frame state; drop back to the start state after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_frame_end)) begin
            r_byte_count <= '0;
            r_crc        <= CRC_INIT;
            r_type       <= '0;
            r_length     <= '0;
            r_rx_crc     <= '0;
            r_magic_ok   <= 1'b1;
            r_version_ok <= 1'b1;
            r_body_end   <= END_W'(HDR_BYTES);
            r_crc_end    <= END_W'(MIN_FRAME);
        end else if (accept) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_type       <= n_type;
            r_length     <= n_length;
            r_rx_crc     <= n_rx_crc;
            r_magic_ok   <= n_magic_ok;
            r_version_ok <= n_version_ok;
            r_body_end   <= n_body_end;
            r_crc_end    <= n_crc_end;
        end
    end

    // Result queue
    crcfd_res_fifo #(
        .DEPTH (DEPTH)
    ) u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_data0    (res_d0),
        .i_data1    (res_st),
        .i_pop      (pop),
        .o_head     (head),
        .o_count    (q_count)
    );

    // Stall the input when two items may not fit
    assign o_stall = q_count > QCNT_W'(DEPTH - 2);
    assign o_valid = q_count != '0;
    assign pop     = o_valid && !i_stall;

    assign o_kind           = head.kind;
    assign o_payload_byte   = head.payload_byte;
    assign o_msg_type       = head.msg_type;
    assign o_payload_length = head.payload_length;
    assign o_status         = head.status;
    assign o_last           = head.last;

endmodule

>>> sv/crcfd_res_fifo.sv
// Result queue: takes up to two result items a cycle, hands out one per i_pop.
module crcfd_res_fifo
    import crcfd_pkg::*;
#(
    parameter int unsigned DEPTH = RES_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_cnt,
    input  t_result                    i_data0,
    input  t_result                    i_data1,
    input  logic                       i_pop,
    output t_result                    o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

    t_result             r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W_Q-1:0]  r_count;
    logic [PTR_W-1:0]    n_wr_ptr1;

    assign n_wr_ptr1 = r_wr_ptr + PTR_W'(1);
    assign o_head    = r_mem[r_rd_ptr];
    assign o_count   = r_count;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[n_wr_ptr1] <= i_data1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W_Q'(i_push_cnt) - CNT_W_Q'(i_pop);
        end
    end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the CRC-32 frame decoder.
`timescale 1ns / 1ps

module testbench
    import crcfd_pkg::*;
();

    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } t_rx_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_rx_byte = 8'd0;
    logic                 i_frame_end = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_kind;
    logic [7:0]           o_payload_byte;
    logic [15:0]          o_msg_type;
    logic [31:0]          o_payload_length;
    logic [2:0]           o_status;
    logic                 o_last;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    crc32_frame_decoder dut (.*);

    // Decoder mirror: frame state and register copies
    logic [CNT_W-1:0] fr_count;
    logic [31:0]      fr_crc;
    logic [15:0]      fr_type;
    logic [31:0]      fr_len;
    logic [31:0]      fr_rx_crc;
    logic             fr_magic_ok;
    logic             fr_ver_ok;
    logic [15:0]      cfg_magic;
    logic [7:0]       cfg_version;

    t_result     decoded_q[$];
    t_rx_item    rx_q[$];
    int unsigned rx_pushed = 0;
    int unsigned err_cnt = 0;

    // Handshake bookkeeping shared between the clocked processes
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned rx_gap = 0;
    int unsigned res_wait = 0;
    int unsigned in_gap_max = 4;
    int unsigned out_gap_max = 4;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    initial begin : clock_gen
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #500000;
        $display("[crc32_frame_decoder] ERROR");
        $finish;
    end

    // Fold one byte into a reflected CRC-32, LSB first
    function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void clear_frame();
        fr_count    = '0;
        fr_crc      = CRC_INIT;
        fr_type     = '0;
        fr_len      = '0;
        fr_rx_crc   = '0;
        fr_magic_ok = 1'b1;
        fr_ver_ok   = 1'b1;
    endfunction

    // Advance the mirror by one byte and queue the results it yields
    function automatic void decode_frame_byte(input logic [7:0] b, input logic fin);
        longint unsigned pos;
        longint unsigned body_end;
        longint unsigned n_bytes;
        t_result         r;
        t_status         st;
        pos      = longint'(fr_count);
        body_end = 64'(HDR_BYTES) + 64'(fr_len);

        if (pos == 0) fr_magic_ok = (b == cfg_magic[15:8]);
        else if (pos == 1) fr_magic_ok = fr_magic_ok && (b == cfg_magic[7:0]);
        else if (pos == 2) fr_ver_ok = (b == cfg_version);
        else if (pos == 4 || pos == 5) fr_type = {fr_type[7:0], b};
        else if (pos >= 6 && pos < HDR_BYTES) fr_len = {fr_len[23:0], b};

        if (pos < HDR_BYTES) begin
            fr_crc = crc32_fold(fr_crc, b);
        end else if (pos < body_end) begin
            fr_crc           = crc32_fold(fr_crc, b);
            r.kind           = 1'b0;
            r.payload_byte   = b;
            r.msg_type       = '0;
            r.payload_length = '0;
            r.status         = ST_OK;
            r.last           = 1'b0;
            decoded_q.insert(decoded_q.size(), r);
        end else if (pos < body_end + CRC_BYTES) begin
            fr_rx_crc = {fr_rx_crc[23:0], b};
        end

        // Saturate the byte counter
        if (fr_count != '1) fr_count = fr_count + CNT_W'(1);

        if (fin) begin
            n_bytes = longint'(fr_count);
            if (n_bytes < MIN_FRAME) st = ST_TOO_SHORT;
            else if (!fr_magic_ok) st = ST_BAD_MAGIC;
            else if (!fr_ver_ok) st = ST_BAD_VERSION;
            else if (n_bytes < 64'(HDR_BYTES) + 64'(fr_len) + 64'(CRC_BYTES)) st = ST_BAD_LENGTH;
            else if (fr_rx_crc != ~fr_crc) st = ST_CRC_ERR;
            else st = ST_OK;
            r.kind           = 1'b1;
            r.payload_byte   = '0;
            r.msg_type       = fr_type;
            r.payload_length = fr_len;
            r.status         = st;
            r.last           = 1'b1;
            decoded_q.insert(decoded_q.size(), r);
            clear_frame();
        end
    endfunction

    // Record accepted bytes and predict their results
    always @(posedge i_clk) begin : byte_taker
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) decode_frame_byte(i_rx_byte, i_frame_end);
    end

    // Present queued bytes, with a random gap after each item
    always @(negedge i_clk) begin : byte_driver
        t_rx_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (rx_gap != 0) begin
                rx_gap  <= rx_gap - 1;
                i_valid <= 1'b0;
            end else if (rx_q.size() != 0) begin
                nxt = rx_q.pop_front();
                i_valid     <= 1'b1;
                i_rx_byte   <= nxt.b;
                i_frame_end <= nxt.fin;
                rx_gap      <= $urandom_range(0, in_gap_max);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Count down a long receiver hold-off on request
    always @(negedge i_clk) begin : long_hold
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Stall the result side for a random number of cycles per item, and throughout a long hold-off
    always @(negedge i_clk) begin : result_stall
        int unsigned w;
        w = out_taken ? $urandom_range(0, out_gap_max) : res_wait;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall  <= 1'b1;
            res_wait <= w;
        end else begin
            i_stall  <= (w != 0);
            res_wait <= (w != 0) ? w - 1 : 0;
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        out_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result: kind %0d status %0d", o_kind, o_status);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("msg_type", want.msg_type, o_msg_type);
                check_field("payload_length", want.payload_length, o_payload_length);
                check_field("status", want.status, o_status);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Build a frame and queue its bytes; keep != 0 truncates it
    task automatic queue_frame(input logic [15:0] mg, input logic [7:0] ver,
                               input logic [15:0] typ, input logic [31:0] len_field,
                               input int unsigned n_pay, input int unsigned keep,
                               input int unsigned extra, input bit crc_flip);
        logic [7:0]  fb[$];
        logic [79:0] hdr;
        logic [31:0] c;
        t_rx_item    it;
        hdr = {mg, ver, 8'($urandom), typ, len_field};
        for (int k = 9; k >= 0; k--) fb.insert(fb.size(), hdr[k*8 +: 8]);
        repeat (n_pay) fb.insert(fb.size(), 8'($urandom));
        c = CRC_INIT;
        foreach (fb[i]) c = crc32_fold(c, fb[i]);
        c = ~c;
        if (crc_flip) c = c ^ (32'h1 << $urandom_range(0, 31));
        for (int k = 3; k >= 0; k--) fb.insert(fb.size(), c[k*8 +: 8]);
        repeat (extra) fb.insert(fb.size(), 8'($urandom));
        while (keep != 0 && fb.size() > keep) void'(fb.pop_back());
        foreach (fb[i]) begin
            it.b   = fb[i];
            it.fin = (i == fb.size() - 1);
            rx_q.insert(rx_q.size(), it);
        end
        rx_pushed += fb.size();
    endtask

    // Wait until all bytes are in and every prediction is matched
    task automatic wait_drained();
        do @(posedge i_clk); while (rx_q.size() != 0 || i_valid || decoded_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_MAGIC) cfg_magic = data;
        else if (idx == CFG_VERSION) cfg_version = data[7:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly good frames with random content, the rest defective or noise
    task automatic run_phase(input int unsigned n_items, input int unsigned in_max,
                             input int unsigned out_max, input bit squeeze);
        int unsigned start;
        int unsigned n_pay;
        int unsigned keep;
        int unsigned extra;
        int unsigned roll;
        logic [15:0] mg;
        logic [7:0]  ver;
        logic [31:0] len_field;
        bit          crc_flip;
        @(posedge i_clk);
        in_gap_max  = in_max;
        out_gap_max = out_max;
        start       = rx_pushed;
        if (squeeze) begin
            hold_req++;
            queue_frame(cfg_magic, cfg_version, 16'($urandom), 32'd60, 60, 0, 0, 1'b0);
        end
        while (rx_pushed - start < n_items) begin
            roll      = $urandom_range(0, 99);
            n_pay     = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            mg        = cfg_magic;
            ver       = cfg_version;
            len_field = n_pay;
            keep      = 0;
            extra     = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            crc_flip  = 1'b0;
            if (roll < 5) begin
                // noise
                mg        = 16'($urandom);
                ver       = 8'($urandom);
                len_field = $urandom;
                keep      = $urandom_range(1, 24);
            end else if (roll >= 60) begin
                // stack defects so that the status precedence gets exercised
                do begin
                    if ($urandom_range(0, 2) == 0) mg = mg ^ (16'h1 << $urandom_range(0, 15));
                    if ($urandom_range(0, 2) == 0) ver = ver ^ (8'h1 << $urandom_range(0, 7));
                    if ($urandom_range(0, 2) == 0) crc_flip = 1'b1;
                    if ($urandom_range(0, 2) == 0) begin
                        case ($urandom_range(0, 2))
                            0:       len_field = n_pay + $urandom_range(1, 4);
                            1:       len_field = $urandom | 32'h8000_0000;
                            default: len_field = $urandom_range(0, n_pay);
                        endcase
                    end
                    if ($urandom_range(0, 2) == 0) keep = $urandom_range(1, 13 + n_pay);
                end while (mg == cfg_magic && ver == cfg_version && !crc_flip
                           && len_field == n_pay && keep == 0);
            end
            queue_frame(mg, ver, 16'($urandom), len_field, n_pay, keep, extra, crc_flip);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        cfg_magic   = MAGIC_RST;
        cfg_version = VERSION_RST;
        clear_frame();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-byte frame, frame cut inside the length field, minimal good frame
        queue_frame(16'hFF00, 8'h00, 16'h0000, 32'd0, 0, 1, 0, 1'b0);
        queue_frame(MAGIC_RST, VERSION_RST, 16'hA5C3, 32'h1234_5678, 0, 8, 0, 1'b0);
        queue_frame(MAGIC_RST, VERSION_RST, 16'hFFFF, 32'd0, 0, 0, 0, 1'b0);
        wait_drained();

        run_phase(170, 4, 4, 1'b0);

        write_reg(CFG_MAGIC, 16'h0000);
        write_reg(CFG_VERSION, 16'h0000);
        write_reg(CFG_SPARE_A, 16'($urandom));
        run_phase(170, 0, 0, 1'b0);

        write_reg(CFG_MAGIC, 16'hFFFF);
        write_reg(CFG_VERSION, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'($urandom));
        run_phase(170, 1, 4, 1'b1);

        write_reg(CFG_MAGIC, 16'($urandom));
        write_reg(CFG_VERSION, 16'($urandom));
        run_phase(170, 2, 4, 1'b0);

        if (err_cnt == 0) begin
            $display("[crc32_frame_decoder] OK");
        end else begin
            $display("[crc32_frame_decoder] ERROR");
        end
        $finish;
    end

endmodule
